[src/gfconv_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the GF(2^N) representation converter.
// No dependencies; used by the top level and its port checker.
package gfconv_pkg;

	localparam int FIELD_DEGREE_DEF = 8;
	localparam int MAX_DEGREE       = 16;

	localparam int ELEM_W  = 8;   // payload width of src/dst elements
	localparam int REG_W   = 8;   // configuration register width
	localparam int CFG_IDX_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_MOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_GEN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_MOD = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_GEN = 8'd3;

	localparam logic [REG_W-1:0] SRC_MOD_RST = 8'd29;
	localparam logic [REG_W-1:0] SRC_GEN_RST = 8'd2;
	localparam logic [REG_W-1:0] DST_MOD_RST = 8'd27;
	localparam logic [REG_W-1:0] DST_GEN_RST = 8'd3;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

[src/gf2n_field_representation_convert.sv]
`timescale 1ns / 1ps
// GF(2^N) representation converter: discrete log in the source field,
// exponentiation in the destination field. Uses gfconv_pkg.
//
// Channel   Dir  Handshake            Payload
// s_axis    in   s_tvalid / s_tready  s_tdata[7:0] = src_element
// m_axis    out  m_tvalid / m_tready  m_tdata[7:0] = dst_element, m_tuser = not_found
// cfg       in   cfg_valid/cfg_ready  cfg_index = register, cfg_data = value
//
// A zero input goes straight to the result; otherwise the search stops at a
// match at power k, or after the last power, 2^N-2, when nothing matches.
// The search speed is set by the single step unit: one multiply-and-reduce pair per cycle.
// Reset puts the config registers at their documented defaults; no clearing pass.
// One item is in flight at a time; s_tready is low from accept until the
// result transaction completes, and a stalled result simply holds.
module gf2n_field_representation_convert #(
	parameter int FIELD_DEGREE = gfconv_pkg::FIELD_DEGREE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [gfconv_pkg::ELEM_W-1:0]       s_tdata,   // [7:0] src_element
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [gfconv_pkg::ELEM_W-1:0]       m_tdata,   // [7:0] dst_element
	output logic                                m_tuser,   // [0] not_found
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gfconv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gfconv_pkg::REG_W-1:0]        cfg_data
);

	localparam int N = FIELD_DEGREE;
	localparam int CMP_W = gfconv_pkg::MAX_DEGREE;
	// last step index of the search, 2^N - 2
	localparam logic [N-1:0] LAST_STEP = N'((1 << N) - 2);

	// multiply by generator and reduce mod x^N + low, MSB-first shift/xor
	function automatic logic [N-1:0] fmul(input logic [N-1:0] a, input logic [N-1:0] b,
		input logic [N-1:0] low);
		logic [N-1:0] r;
		logic         carry;
		r = '0;
		for (int i = N - 1; i >= 0; i--) begin
			carry = r[N-1];
			r = r << 1;
			if (carry) begin
				r = r ^ low;
			end
			if (b[i]) begin
				r = r ^ a;
			end
		end
		return r;
	endfunction

	// configuration registers
	logic [gfconv_pkg::REG_W-1:0] src_mod_q, src_gen_q, dst_mod_q, dst_gen_q;

	gfconv_pkg::state_t state_q;
	logic [gfconv_pkg::ELEM_W-1:0] target_q;   // element being searched for
	logic [N-1:0] p1_q, p2_q;                  // src and dst power chains
	logic [N-1:0] step_q;
	logic [gfconv_pkg::ELEM_W-1:0] res_q;
	logic nf_q;

	logic [N-1:0] src_gen, dst_gen, src_low, dst_low;
	logic [N-1:0] p1_nxt, p2_nxt;
	logic hit;
	logic in_acc, out_acc;

	// register bits at or above x^N are ignored
	assign src_gen = N'(src_gen_q);
	assign dst_gen = N'(dst_gen_q);
	assign src_low = N'(src_mod_q);
	assign dst_low = N'(dst_mod_q);

	// the step unit: advances both chains one power
	assign p1_nxt = fmul(p1_q, src_gen, src_low);
	assign p2_nxt = fmul(p2_q, dst_gen, dst_low);

	// unreduced inputs can never match a reduced power
	assign hit = (CMP_W'(p1_q) == CMP_W'(target_q));

	assign s_tready  = (state_q == gfconv_pkg::ST_IDLE);
	assign m_tvalid  = (state_q == gfconv_pkg::ST_DONE);
	assign m_tdata   = res_q;
	assign m_tuser   = nf_q;
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign out_acc   = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_mod_q <= gfconv_pkg::SRC_MOD_RST;
			src_gen_q <= gfconv_pkg::SRC_GEN_RST;
			dst_mod_q <= gfconv_pkg::DST_MOD_RST;
			dst_gen_q <= gfconv_pkg::DST_GEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gfconv_pkg::REG_SRC_MOD: src_mod_q <= cfg_data;
				gfconv_pkg::REG_SRC_GEN: src_gen_q <= cfg_data;
				gfconv_pkg::REG_DST_MOD: dst_mod_q <= cfg_data;
				gfconv_pkg::REG_DST_GEN: dst_gen_q <= cfg_data;
				default: ;   // unknown index: dropped
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfconv_pkg::ST_IDLE;
		end else begin
			case (state_q)
				gfconv_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= (s_tdata == '0) ? gfconv_pkg::ST_DONE : gfconv_pkg::ST_RUN;
					end
				end
				gfconv_pkg::ST_RUN: begin
					if (hit || step_q == LAST_STEP) begin
						state_q <= gfconv_pkg::ST_DONE;
					end
				end
				gfconv_pkg::ST_DONE: begin
					if (out_acc) begin
						state_q <= gfconv_pkg::ST_IDLE;
					end
				end
				default: state_q <= gfconv_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			target_q <= s_tdata;
			p1_q     <= N'(1);
			p2_q     <= N'(1);
			step_q   <= '0;
			res_q    <= '0;      // zero maps to zero
			nf_q     <= 1'b0;
		end else if (state_q == gfconv_pkg::ST_RUN) begin
			if (hit) begin
				res_q <= gfconv_pkg::ELEM_W'(p2_q);
				nf_q  <= 1'b0;
			end else if (step_q == LAST_STEP) begin
				res_q <= '0;
				nf_q  <= 1'b1;
			end else begin
				p1_q   <= p1_nxt;
				p2_q   <= p2_nxt;
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

[src/gfconv_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the GF(2^N) converter, bound to the top level.
// Depends on gfconv_pkg for payload widths.
module gfconv_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [gfconv_pkg::ELEM_W-1:0]      s_tdata,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [gfconv_pkg::ELEM_W-1:0]      m_tdata,
	input logic                               m_tuser
);

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item in flight: never ready for input while a result is shown
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	// zero input answers zero, found, on the next cycle
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata == '0 |=> m_tvalid && m_tdata == '0 && !m_tuser)
		else $error("zero input not mapped to zero");

	// not-found results carry zero data
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("not_found with nonzero data");

endmodule

bind gf2n_field_representation_convert gfconv_checker u_gfconv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[test/gf2n_field_representation_convert_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for gf2n_field_representation_convert: a scoreboard
// predicts each conversion by stepping both power chains itself.
// Depends on gfconv_pkg and the converter top level only.
module gf2n_field_representation_convert_tb;

	localparam int N              = gfconv_pkg::FIELD_DEGREE_DEF;
	localparam int ELEM_W         = gfconv_pkg::ELEM_W;
	localparam int REG_W          = gfconv_pkg::REG_W;
	localparam int CFG_IDX_W      = gfconv_pkg::CFG_IDX_W;
	localparam int CHAIN_STEPS    = (1 << N) - 1;   // full search length
	localparam int QUIET_LIMIT    = 2000;           // cycles with no transaction at all
	localparam int DRAIN_CYCLES   = 300;            // > one full search
	localparam int RAND_PHASES    = 11;
	localparam int ITEMS_PER_PHASE = 100;

	// indexes outside the register file, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = {CFG_IDX_W{1'b1}};

	// low parts of primitive degree-8 polynomials, so half of all random
	// generators (128 of the 256 values) span the whole group
	localparam logic [REG_W-1:0] PRIM_LOW [16] = '{
		8'h1D, 8'h2B, 8'h2D, 8'h4D, 8'h5F, 8'h63, 8'h65, 8'h69,
		8'h71, 8'h87, 8'h8D, 8'hA9, 8'hC3, 8'hCF, 8'hE7, 8'hF5
	};

	// reset config: 0 and 1 trivially, 2 is the generator itself, 0x8E is
	// 2^254 (last step of the chain), the rest spread over the bit patterns
	localparam logic [ELEM_W-1:0] DIRECTED [12] = '{
		8'h00, 8'h01, 8'h02, 8'h03, 8'h80, 8'h7F,
		8'hFF, 8'hFE, 8'h55, 8'hAA, 8'h1D, 8'h8E
	};

	typedef struct packed {
		logic [ELEM_W-1:0] dst_element;
		logic              not_found;
	} conv_result_t;

	// Holds a copy of the four registers and the queue of pending conversions.
	class conv_scoreboard;
		logic [REG_W-1:0] src_mod, src_gen, dst_mod, dst_gen;
		conv_result_t     expected_q[$];
		int               errors;

		function new();
			src_mod = gfconv_pkg::SRC_MOD_RST;
			src_gen = gfconv_pkg::SRC_GEN_RST;
			dst_mod = gfconv_pkg::DST_MOD_RST;
			dst_gen = gfconv_pkg::DST_GEN_RST;
			errors  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
			case (idx)
				gfconv_pkg::REG_SRC_MOD: src_mod = val;
				gfconv_pkg::REG_SRC_GEN: src_gen = val;
				gfconv_pkg::REG_DST_MOD: dst_mod = val;
				gfconv_pkg::REG_DST_GEN: dst_gen = val;
				default: ;
			endcase
		endfunction

		// a*b in GF(2)[x] mod x^N + low, MSB-first shift-and-add
		function logic [N-1:0] field_mul(logic [N-1:0] a, logic [N-1:0] b,
				logic [N-1:0] low);
			logic [N:0] acc;
			acc = '0;
			for (int i = N - 1; i >= 0; i--) begin
				acc = acc << 1;
				if (acc[N])
					acc ^= {1'b1, low};
				if (b[i])
					acc ^= {1'b0, a};
			end
			return acc[N-1:0];
		endfunction

		// src_gen^k, used to build inputs that the search will find
		function logic [ELEM_W-1:0] src_power(int k);
			logic [N-1:0] p;
			p = 1;
			for (int i = 0; i < k; i++)
				p = field_mul(p, src_gen[N-1:0], src_mod[N-1:0]);
			return p;
		endfunction

		function conv_result_t convert(logic [ELEM_W-1:0] elem);
			logic [N-1:0] p_src, p_dst;
			conv_result_t res;
			res   = '0;
			p_src = 1;
			p_dst = 1;
			if (elem == '0)
				return res;
			for (int i = 0; i < CHAIN_STEPS; i++) begin
				if (p_src == elem) begin
					res.dst_element = p_dst;
					return res;
				end
				p_src = field_mul(p_src, src_gen[N-1:0], src_mod[N-1:0]);
				p_dst = field_mul(p_dst, dst_gen[N-1:0], dst_mod[N-1:0]);
			end
			res.not_found = 1'b1;
			return res;
		endfunction

		function void note_input(logic [ELEM_W-1:0] elem);
			expected_q.push_back(convert(elem));
		endfunction

		function void check_result(logic [ELEM_W-1:0] dst_element, logic not_found);
			conv_result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("result with nothing pending: dst_element %0h not_found %0b",
					dst_element, not_found);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (dst_element !== exp_res.dst_element) begin
				$error("dst_element: expected %0h actual %0h",
					exp_res.dst_element, dst_element);
				errors++;
			end
			if (not_found !== exp_res.not_found) begin
				$error("not_found: expected %0b actual %0b",
					exp_res.not_found, not_found);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [ELEM_W-1:0]    s_tdata   = '0;     // [7:0] src_element
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [ELEM_W-1:0]    m_tdata;            // [7:0] dst_element
	logic                 m_tuser;            // [0] not_found
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data  = '0;

	conv_scoreboard sb;
	int send_idle  = 0;   // percent of cycles the sender holds off
	int recv_stall = 0;   // percent of cycles the receiver drops m_tready
	int quiet_cycles = 0;

	gf2n_field_representation_convert #(
		.FIELD_DEGREE(N)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: one draw per edge, so m_tready gets a single update per step
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall);
	end

	// monitor: every transaction is sampled at the edge that completes it.
	// Results are checked before a new input is noted, so a result and an
	// accept on the same edge would still pair up correctly.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata);
		end
	end

	// watchdog: a search ends at the last power of the chain, so a long quiet stretch
	// means the block has hung
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// One input transaction, preceded by a random hold-off. s_tvalid stays
	// high between back-to-back items.
	task automatic send_elem(input logic [ELEM_W-1:0] elem);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= elem;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// All four registers, then a write to an unused index that must not
	// disturb them.
	task automatic program_regs(input logic [REG_W-1:0] sm, input logic [REG_W-1:0] sg,
			input logic [REG_W-1:0] dm, input logic [REG_W-1:0] dg);
		write_cfg(gfconv_pkg::REG_SRC_MOD, sm);
		write_cfg(gfconv_pkg::REG_SRC_GEN, sg);
		write_cfg(gfconv_pkg::REG_DST_MOD, dm);
		write_cfg(gfconv_pkg::REG_DST_GEN, dg);
		write_cfg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
			REG_W'($urandom_range(0, 255)));
		cfg_valid <= 1'b0;
	endtask

	// every input yields a result, so an empty queue means the block is idle;
	// one edge first so the monitor has noted the last accepted input
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [REG_W-1:0] pick_modulus();
		if ($urandom_range(0, 1))
			return PRIM_LOW[$urandom_range(0, 15)];
		return REG_W'($urandom_range(0, 255));
	endfunction

	initial begin
		int               sel;
		logic [ELEM_W-1:0] elem;

		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset values, no idling
		foreach (DIRECTED[i])
			send_elem(DIRECTED[i]);
		wait_idle();

		// generator of order one: only 0 and 1 are found, everything else misses
		program_regs(gfconv_pkg::SRC_MOD_RST, 8'h01, gfconv_pkg::DST_MOD_RST,
			gfconv_pkg::DST_GEN_RST);
		send_elem(8'h00);
		send_elem(8'h01);
		send_elem(8'h02);
		send_elem(8'hFF);
		wait_idle();

		for (int ph = 1; ph <= RAND_PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 74; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 74; end
				default: begin send_idle = 18; recv_stall = 18; end
			endcase

			// extremes first: zero generator with modulus x^N, then all ones
			// (reducible modulus); after that random settings
			if (ph == 1)
				program_regs(8'h00, 8'h00, 8'h00, 8'h00);
			else if (ph == 2)
				program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
			else
				program_regs(pick_modulus(), REG_W'($urandom_range(0, 255)),
					pick_modulus(), REG_W'($urandom_range(0, 255)));

			// mostly true powers of the generator so matches land at all
			// depths of the chain; the rest zero or arbitrary elements
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 70)
					elem = sb.src_power($urandom_range(0, CHAIN_STEPS - 1));
				else if (sel < 75)
					elem = '0;
				else
					elem = ELEM_W'($urandom_range(0, 255));
				send_elem(elem);
			end
			wait_idle();
		end

		// anything arriving now has no expectation and is flagged
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
